@@ sv/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Fixed field widths of the channels
  localparam int VCOUNT_W = 9;
  localparam int INDEX_W  = 8;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr;       // store the input vertex
    logic rd;       // issue a vertex read
    logic lead;     // this read only primes the previous-vertex register
    logic load_pt;  // capture the test point and clear the inside flag
  } pip_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;     // edge pipeline still holds beats
    logic flag;     // running inside flag
  } pip_sts_t;

endpackage

@@ sv/pip_ram.sv @@
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pip_datapath.sv @@
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex store and edge pipeline: one edge per beat, exact crossing test
// by sign-magnitude cross-multiplication, running even-odd flag.
// ----------------------------------------------------------------------------
module pip_datapath #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 32,
  localparam int ADDR_W = $clog2(MAX_VERTICES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pip_pkg::pip_cmd_t             cmd,
  input  logic [ADDR_W-1:0]             rd_addr,
  input  logic [pip_pkg::INDEX_W-1:0]   vertex_index,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  output pip_pkg::pip_sts_t             sts
);

  import pip_pkg::*;

  localparam int DW = COORD_WIDTH + 1;  // difference width
  localparam int LW = (DW + 1) / 2;     // low split of a magnitude
  localparam int HW = DW - LW;          // high split of a magnitude
  localparam int PW = 2 * DW;           // product width

  logic [2*COORD_WIDTH-1:0] ram_rdata;

  logic signed [COORD_WIDTH-1:0] tx, ty;
  logic signed [COORD_WIDTH-1:0] cur_x, cur_y, prev_x, prev_y;
  logic signed [DW-1:0] cx, cy, px, py, ex, ey;

  // Stage A: read data
  logic va, lead_a;
  // Stage B: signed differences
  logic vb, strad_b;
  logic signed [DW-1:0] dy_b, dxt_b, dx_b, dyt_b;
  // Stage C: sign and magnitude
  logic vc, strad_c, ndy_c, nl_c, nr_c;
  logic [DW-1:0] m_dy_c, m_dxt_c, m_dx_c, m_dyt_c;
  // Stage D: partial products
  logic vd, strad_d, ndy_d, nl_d, nr_d;
  logic [2*LW-1:0]   pl_ll, pr_ll;
  logic [LW+HW-1:0]  pl_lh, pl_hl, pr_lh, pr_hl;
  logic [2*HW-1:0]   pl_hh, pr_hh;
  // Stage E: full products
  logic ve, strad_e, ndy_e, nl_e, nr_e;
  logic [PW-1:0] ml_e, mr_e;

  logic l_gt_r, l_lt_r, crosses;
  logic flag;

  pip_ram #(
    .WIDTH(2 * COORD_WIDTH),
    .DEPTH(MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (ADDR_W'(vertex_index)),
    .wdata ({point_y, point_x}),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign cur_x = ram_rdata[COORD_WIDTH-1:0];
  assign cur_y = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign cx = {cur_x[COORD_WIDTH-1], cur_x};
  assign cy = {cur_y[COORD_WIDTH-1], cur_y};
  assign px = {prev_x[COORD_WIDTH-1], prev_x};
  assign py = {prev_y[COORD_WIDTH-1], prev_y};
  assign ex = {tx[COORD_WIDTH-1], tx};
  assign ey = {ty[COORD_WIDTH-1], ty};

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      va <= cmd.rd;
      vb <= va & ~lead_a;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  // Test point and previous vertex
  always_ff @(posedge clk) begin
    lead_a <= cmd.lead;
    if (cmd.load_pt) begin
      tx <= point_x;
      ty <= point_y;
    end
    if (va) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  // Stage B: edge from previous vertex j to current vertex i
  always_ff @(posedge clk) begin
    strad_b <= (cur_y > ty) != (prev_y > ty);
    dy_b    <= py - cy;
    dxt_b   <= ex - cx;
    dx_b    <= px - cx;
    dyt_b   <= ey - cy;
  end

  // Stage C: a zero factor makes a positive-signed product
  always_ff @(posedge clk) begin
    strad_c <= strad_b;
    ndy_c   <= dy_b[DW-1];
    nl_c    <= (dxt_b[DW-1] ^ dy_b[DW-1]) & (dxt_b != '0) & (dy_b != '0);
    nr_c    <= (dx_b[DW-1] ^ dyt_b[DW-1]) & (dx_b != '0) & (dyt_b != '0);
    m_dy_c  <= dy_b[DW-1]  ? $unsigned(-dy_b)  : $unsigned(dy_b);
    m_dxt_c <= dxt_b[DW-1] ? $unsigned(-dxt_b) : $unsigned(dxt_b);
    m_dx_c  <= dx_b[DW-1]  ? $unsigned(-dx_b)  : $unsigned(dx_b);
    m_dyt_c <= dyt_b[DW-1] ? $unsigned(-dyt_b) : $unsigned(dyt_b);
  end

  // Stage D: split each magnitude product into four partial products
  always_ff @(posedge clk) begin
    strad_d <= strad_c;
    ndy_d   <= ndy_c;
    nl_d    <= nl_c;
    nr_d    <= nr_c;
    pl_ll   <= m_dxt_c[LW-1:0]  * m_dy_c[LW-1:0];
    pl_lh   <= m_dxt_c[LW-1:0]  * m_dy_c[DW-1:LW];
    pl_hl   <= m_dxt_c[DW-1:LW] * m_dy_c[LW-1:0];
    pl_hh   <= m_dxt_c[DW-1:LW] * m_dy_c[DW-1:LW];
    pr_ll   <= m_dx_c[LW-1:0]   * m_dyt_c[LW-1:0];
    pr_lh   <= m_dx_c[LW-1:0]   * m_dyt_c[DW-1:LW];
    pr_hl   <= m_dx_c[DW-1:LW]  * m_dyt_c[LW-1:0];
    pr_hh   <= m_dx_c[DW-1:LW]  * m_dyt_c[DW-1:LW];
  end

  // Stage E: sum partial products
  always_ff @(posedge clk) begin
    strad_e <= strad_d;
    ndy_e   <= ndy_d;
    nl_e    <= nl_d;
    nr_e    <= nr_d;
    ml_e    <= {pl_hh, pl_ll} + ((PW'(pl_lh) + PW'(pl_hl)) << LW);
    mr_e    <= {pr_hh, pr_ll} + ((PW'(pr_lh) + PW'(pr_hl)) << LW);
  end

  // Signed compare of the two sign-magnitude products
  always_comb begin
    if (nl_e != nr_e) begin
      l_gt_r = nr_e;
      l_lt_r = nl_e;
    end else if (!nl_e) begin
      l_gt_r = ml_e > mr_e;
      l_lt_r = ml_e < mr_e;
    end else begin
      l_gt_r = ml_e < mr_e;
      l_lt_r = ml_e > mr_e;
    end
  end

  assign crosses = strad_e & (ndy_e ? l_gt_r : l_lt_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (cmd.load_pt) begin
      flag <= 1'b0;
    end else if (ve && crosses) begin
      flag <= ~flag;
    end
  end

  assign sts.busy = va | vb | vc | vd | ve;
  assign sts.flag = flag;

endmodule

@@ sv/pip_ctrl.sv @@
// ----------------------------------------------------------------------------
// pip_ctrl
// Controller: vertex count register, input handshake, edge walk sequencer
// and the output register.
// ----------------------------------------------------------------------------
module pip_ctrl #(
  parameter int MAX_VERTICES = 256,
  localparam int ADDR_W = $clog2(MAX_VERTICES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [pip_pkg::VCOUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [pip_pkg::INDEX_W-1:0]  vertex_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res,
  output pip_pkg::pip_cmd_t            cmd,
  output logic [ADDR_W-1:0]            rd_addr,
  input  pip_pkg::pip_sts_t            sts
);

  import pip_pkg::*;

  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int CMW = (NW > VCOUNT_W) ? NW : VCOUNT_W;
  localparam int IXW = (NW > INDEX_W) ? NW : INDEX_W;

  pip_state_t state, state_next;

  logic [VCOUNT_W-1:0] vertex_count;
  logic [NW-1:0]       n_sat;
  logic                n_zero;
  logic                idx_ok;
  logic [ADDR_W-1:0]   n_last;
  logic [ADDR_W-1:0]   cnt;
  logic                last;
  logic                load_out;
  logic                query_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // Clamp the count to the store depth
  assign n_sat  = (CMW'(vertex_count) > CMW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                             : NW'(vertex_count);
  assign n_zero = (n_sat == '0);
  assign idx_ok = IXW'(vertex_index) < IXW'(MAX_VERTICES);
  assign last   = (cnt == n_last);
  assign query_acc = (state == ST_IDLE) && in_valid && (kind == KIND_QUERY);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && kind == KIND_QUERY) begin
          state_next = n_zero ? ST_FINISH : ST_LEAD;
        end
      end
      ST_LEAD:  state_next = ST_WALK;
      ST_WALK: begin
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    rd_addr  = cnt;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.wr      = in_valid && (kind == KIND_WRITE) && idx_ok;
        cmd.load_pt = in_valid && (kind == KIND_QUERY);
      end
      ST_LEAD: begin
        cmd.rd   = 1'b1;
        cmd.lead = 1'b1;
        rd_addr  = n_last;
      end
      ST_WALK: begin
        cmd.rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LEAD) begin
        cnt <= '0;
      end else if (state == ST_WALK) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      n_last <= ADDR_W'(n_sat - NW'(1));
    end
    if (load_out) begin
      inside_res <= sts.flag;
    end
  end

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> state != ST_IDLE)
    else $error("query accepted but controller stayed idle");

  a_finish_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> !sts.busy)
    else $error("result taken while edge pipeline still busy");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> cnt <= n_last)
    else $error("walk index ran past last vertex");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish state");

endmodule

@@ sv/point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-crossing test of a point against a stored polygon.
// ----------------------------------------------------------------------------
// Write beat: stores a vertex when vertex_index < MAX_VERTICES, no result.
// Query beat: n = min(vertex_count, MAX_VERTICES); result valid once the edge
//   pipeline drains (no walk when n is zero); next beat taken after that.
// Throughput: one edge per cycle, set by the single read port of the vertex
//   RAM.
// Reset: clears control, vertex_count and out_valid; inside_res and vertex RAM undefined.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // vertex_count register
  input  logic                          cfg_write,
  input  logic [pip_pkg::VCOUNT_W-1:0]  cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [pip_pkg::INDEX_W-1:0]   vertex_index,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          inside_res
);

  import pip_pkg::*;

  localparam int ADDR_W = $clog2(MAX_VERTICES);

  pip_cmd_t          cmd;
  pip_sts_t          sts;
  logic [ADDR_W-1:0] rd_addr;

  // Controller: count register, handshake and walk sequencing. A query
  // reads the last vertex first to prime the previous-vertex register,
  // then vertices 0 .. n-1, one read a cycle; each read after the first
  // forms one edge.
  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .vertex_index (vertex_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .inside_res   (inside_res),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .sts          (sts)
  );

  // Datapath: vertex RAM plus a five-stage edge pipeline (read, differences,
  // sign/magnitude, partial products, product sums) feeding the flag. The
  // crossing test compares (tx - xi) * dy against (xj - xi) * (ty - yi),
  // with the sense flipped when dy is negative, so no divide is needed.
  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .vertex_index (vertex_index),
    .point_x      (point_x),
    .point_y      (point_y),
    .sts          (sts)
  );

endmodule
